// ===== hw/rtl/fm_voice_fingerprint_unit_assert.svh =====
// assertion macros for the fm voice fingerprint unit
`ifndef FM_VOICE_FINGERPRINT_UNIT_ASSERT_SVH
`define FM_VOICE_FINGERPRINT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// implication or plain property checked on every clock edge out of reset
`define FVF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fvf assertion failed");

// condition that must never hold out of reset
`define FVF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("fvf forbidden condition seen");

`else

`define FVF_ASSERT(lbl, clk, rst_n, prop)
`define FVF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/fvf_pkg.sv =====
// shared types and constants of the fm voice fingerprint unit
`timescale 1ns / 1ps

package fvf_pkg;

	typedef enum logic [1:0] {
		EV_RAW      = 2'd0,
		EV_NOTE_ON  = 2'd1,
		EV_NOTE_OFF = 2'd2
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH
	} back_state_t;

	// classified command held in the queue between front and back
	typedef struct packed {
		event_kind_t kind;
		logic [8:0]  reg_address;
		logic [7:0]  write_data;
		logic [2:0]  channel;
		logic [7:0]  key_slots;
		logic        bank;
		logic [1:0]  slot;
		logic        zero_voice;
	} cmd_t;

	localparam int unsigned ShadowAddrWidth = 9;
	localparam int unsigned ApbAddrWidth    = 3;
	localparam int unsigned ApbDataWidth    = 32;

	// register index of probe_enabled, taken from paddr[2]
	localparam logic CfgProbeEnabled = 1'b0;

	localparam logic [2:0] ChannelsPerBank = 3'd3;
	localparam logic [2:0] LastChannel     = 3'd5;
	localparam logic [7:0] RawChannel      = 8'hff;

	localparam logic [63:0] FnvBasis      = 64'hcbf29ce484222325;
	localparam logic [8:0]  FnvPrimeLo    = 9'h1b3;
	localparam int unsigned FnvPrimeShift = 40;

	// shadow register bases
	localparam logic [7:0] RegMulDt  = 8'h30;
	localparam logic [7:0] RegTl     = 8'h40;
	localparam logic [7:0] RegAr     = 8'h50;
	localparam logic [7:0] RegDr     = 8'h60;
	localparam logic [7:0] RegSr     = 8'h70;
	localparam logic [7:0] RegRr     = 8'h80;
	localparam logic [7:0] RegFnumLo = 8'ha0;
	localparam logic [7:0] RegBlock  = 8'ha4;
	localparam logic [7:0] RegAlgFb  = 8'hb0;
	localparam logic [7:0] RegPanLfo = 8'hb4;

	// sequencer steps: 0..27 operator bytes, then channel bytes
	localparam logic [5:0] StepAlg    = 6'd28;
	localparam logic [5:0] StepFb     = 6'd29;
	localparam logic [5:0] StepAms    = 6'd30;
	localparam logic [5:0] StepFms    = 6'd31;
	localparam logic [5:0] StepFnumLo = 6'd32;
	localparam logic [5:0] StepBlock  = 6'd33;
	localparam logic [5:0] StepTone   = 6'd34;
	localparam logic [5:0] LastStep   = 6'd37;

	// operator register groups in hash order
	localparam logic [2:0] GrpTl  = 3'd0;
	localparam logic [2:0] GrpAr  = 3'd1;
	localparam logic [2:0] GrpDr  = 3'd2;
	localparam logic [2:0] GrpSr  = 3'd3;
	localparam logic [2:0] GrpRr  = 3'd4;
	localparam logic [2:0] GrpMul = 3'd5;
	localparam logic [2:0] GrpDt  = 3'd6;

endpackage

// ===== hw/rtl/fvf_in_if.sv =====
// input channel carrying register writes and key events
`timescale 1ns / 1ps

interface fvf_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [8:0] reg_address;
	logic [7:0] write_data;
	logic [2:0] channel;
	logic [7:0] key_slots;

	modport source (
		output valid, mode, reg_address, write_data, channel, key_slots,
		input  ready
	);

	modport sink (
		input  valid, mode, reg_address, write_data, channel, key_slots,
		output ready
	);
endinterface

// ===== hw/rtl/fvf_out_if.sv =====
// output channel carrying decoded events and voice hashes
`timescale 1ns / 1ps

interface fvf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  event_channel;
	logic [8:0]  event_reg;
	logic [7:0]  event_data;
	logic [63:0] timbre_digest;
	logic [63:0] voice_digest;
	logic [2:0]  algorithm;
	logic [2:0]  feedback;
	logic [1:0]  pan;
	logic [1:0]  ams;
	logic [2:0]  fms;
	logic [13:0] blk_fnum;

	modport source (
		output valid, event_kind, event_channel, event_reg, event_data,
		       timbre_digest, voice_digest, algorithm, feedback, pan, ams, fms,
		       blk_fnum,
		input  ready
	);

	modport sink (
		input  valid, event_kind, event_channel, event_reg, event_data,
		       timbre_digest, voice_digest, algorithm, feedback, pan, ams, fms,
		       blk_fnum,
		output ready
	);
endinterface

// ===== hw/rtl/fvf_front.sv =====
// front end: input handshake and event classification
`timescale 1ns / 1ps

module fvf_front (
	fvf_in_if.sink      item_in,
	input  logic        probe_enabled,
	input  logic        clear_busy,
	input  logic        q_full,
	output logic        push,
	output fvf_pkg::cmd_t push_cmd
);

	logic accepted;
	logic bank;

	assign item_in.ready = !clear_busy && !q_full;
	assign accepted      = item_in.valid && item_in.ready;
	// disabled probe swallows the transaction
	assign push          = accepted && probe_enabled;

	assign bank = item_in.channel >= fvf_pkg::ChannelsPerBank;

	always_comb begin
		push_cmd.reg_address = item_in.reg_address;
		push_cmd.write_data  = item_in.write_data;
		push_cmd.channel     = item_in.channel;
		push_cmd.key_slots   = item_in.key_slots;
		push_cmd.bank        = bank;
		push_cmd.slot        = bank ? 2'(item_in.channel - fvf_pkg::ChannelsPerBank)
		                            : item_in.channel[1:0];
		push_cmd.zero_voice  = item_in.channel > fvf_pkg::LastChannel;
		if (!item_in.mode) begin
			push_cmd.kind = fvf_pkg::EV_RAW;
		end else if (|item_in.key_slots[7:4]) begin
			push_cmd.kind = fvf_pkg::EV_NOTE_ON;
		end else begin
			push_cmd.kind = fvf_pkg::EV_NOTE_OFF;
		end
	end

endmodule

// ===== hw/rtl/fvf_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps

module fvf_queue #(
	parameter int unsigned Depth = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fvf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output fvf_pkg::cmd_t pop_cmd,
	output logic          nonempty
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	fvf_pkg::cmd_t   slots_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = count_q == CntW'(Depth);
	assign nonempty = count_q != '0;
	assign pop_cmd  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/fvf_back.sv =====
// back end: register shadow, hash sequencer and result register
`timescale 1ns / 1ps

module fvf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  fvf_pkg::cmd_t q_cmd,
	output logic          pop,
	output logic          clear_busy,
	fvf_out_if.source     result_out
);

	fvf_pkg::back_state_t state_q, state_d;

	logic [7:0] shadow [2**fvf_pkg::ShadowAddrWidth];
	logic [7:0] rd_data_q;

	logic [fvf_pkg::ShadowAddrWidth-1:0] clr_addr_q;
	logic [fvf_pkg::ShadowAddrWidth-1:0] rd_addr;
	logic [fvf_pkg::ShadowAddrWidth-1:0] wr_addr;
	logic [7:0] wr_data;
	logic       mem_we;

	fvf_pkg::cmd_t cur_q;
	logic [5:0]  step_q;
	logic [5:0]  step_s1;
	logic        vld_s1;
	logic [63:0] h_q;
	logic [63:0] timbre_q;
	logic [2:0]  alg_q, fb_q, fms_q;
	logic [1:0]  pan_q, ams_q;
	logic [7:0]  fnum_lo_q;
	logic [5:0]  blk_q;

	logic [7:0]  d;
	logic [7:0]  hbyte;
	logic        hash_en;
	logic [63:0] hx;
	logic [63:0] h_next;
	logic [7:0]  base;
	logic        finish;
	logic        out_free;
	logic        start;

	// result register
	logic        res_valid_q;
	logic        res_load;
	logic [1:0]  r_kind_q, r_kind_d;
	logic [7:0]  r_chan_q, r_chan_d;
	logic [8:0]  r_reg_q, r_reg_d;
	logic [7:0]  r_data_q, r_data_d;
	logic [63:0] r_timbre_q, r_timbre_d;
	logic [63:0] r_voice_q, r_voice_d;
	logic [2:0]  r_alg_q, r_alg_d, r_fb_q, r_fb_d, r_fms_q, r_fms_d;
	logic [1:0]  r_pan_q, r_pan_d, r_ams_q, r_ams_d;
	logic [13:0] r_bfn_q, r_bfn_d;

	assign clear_busy = state_q == fvf_pkg::ST_CLEAR;
	assign out_free   = !res_valid_q || result_out.ready;
	assign finish     = vld_s1 && (step_s1 == fvf_pkg::LastStep);

	// sequencer control
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		start    = 1'b0;
		res_load = 1'b0;
		mem_we   = 1'b0;
		wr_addr  = clr_addr_q;
		wr_data  = '0;
		case (state_q)
			fvf_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (&clr_addr_q) begin
					state_d = fvf_pkg::ST_IDLE;
				end
			end
			fvf_pkg::ST_IDLE: begin
				if (q_nonempty && out_free) begin
					pop = 1'b1;
					case (q_cmd.kind)
						fvf_pkg::EV_RAW: begin
							mem_we   = 1'b1;
							wr_addr  = q_cmd.reg_address;
							wr_data  = q_cmd.write_data;
							res_load = 1'b1;
						end
						fvf_pkg::EV_NOTE_ON: begin
							start   = 1'b1;
							state_d = fvf_pkg::ST_HASH;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			fvf_pkg::ST_HASH: begin
				if (finish) begin
					res_load = 1'b1;
					state_d  = fvf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fvf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fvf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// shadow memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			shadow[wr_addr] <= wr_data;
		end
		rd_data_q <= shadow[rd_addr];
	end

	// read address for the step being issued
	always_comb begin
		if (step_q < fvf_pkg::StepAlg) begin
			case (step_q[4:2])
				fvf_pkg::GrpTl:  base = fvf_pkg::RegTl;
				fvf_pkg::GrpAr:  base = fvf_pkg::RegAr;
				fvf_pkg::GrpDr:  base = fvf_pkg::RegDr;
				fvf_pkg::GrpSr:  base = fvf_pkg::RegSr;
				fvf_pkg::GrpRr:  base = fvf_pkg::RegRr;
				default:         base = fvf_pkg::RegMulDt;
			endcase
			base = base + {4'b0000, step_q[1:0], 2'b00};
		end else begin
			case (step_q)
				fvf_pkg::StepAlg, fvf_pkg::StepFb:   base = fvf_pkg::RegAlgFb;
				fvf_pkg::StepAms, fvf_pkg::StepFms:  base = fvf_pkg::RegPanLfo;
				fvf_pkg::StepFnumLo:                 base = fvf_pkg::RegFnumLo;
				default:                             base = fvf_pkg::RegBlock;
			endcase
		end
		rd_addr = {cur_q.bank, base + {6'b000000, cur_q.slot}};
	end

	// byte picked from the shadow word; invalid channels read as zero
	assign d = cur_q.zero_voice ? 8'h00 : rd_data_q;

	always_comb begin
		hbyte   = '0;
		hash_en = 1'b1;
		if (step_s1 < fvf_pkg::StepAlg) begin
			case (step_s1[4:2])
				fvf_pkg::GrpTl:  hbyte = {1'b0, d[6:0]};
				fvf_pkg::GrpAr,
				fvf_pkg::GrpDr,
				fvf_pkg::GrpSr:  hbyte = {3'b000, d[4:0]};
				fvf_pkg::GrpRr,
				fvf_pkg::GrpMul: hbyte = {4'b0000, d[3:0]};
				fvf_pkg::GrpDt:  hbyte = {5'b00000, d[6:4]};
				default:         hbyte = '0;
			endcase
		end else begin
			case (step_s1)
				fvf_pkg::StepAlg:    hbyte = {5'b00000, d[2:0]};
				fvf_pkg::StepFb:     hbyte = {5'b00000, d[5:3]};
				fvf_pkg::StepAms:    hbyte = {6'b000000, d[5:4]};
				fvf_pkg::StepFms:    hbyte = {5'b00000, d[2:0]};
				fvf_pkg::StepFnumLo,
				fvf_pkg::StepBlock:  hash_en = 1'b0;
				// tone class is bits 10..7 of block_fnum
				fvf_pkg::StepTone:   hbyte = {4'b0000, blk_q[2:0], fnum_lo_q[7]};
				default:             hbyte = '0;
			endcase
		end
	end

	// fnv-1a step: xor then multiply by 2^40 + 0x1b3
	assign hx     = h_q ^ {56'b0, hbyte};
	assign h_next = (hx * 64'(fvf_pkg::FnvPrimeLo)) + (hx << fvf_pkg::FnvPrimeShift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			step_q     <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (clear_busy) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (start) begin
				step_q <= '0;
			end else if (state_q == fvf_pkg::ST_HASH && step_q <= fvf_pkg::LastStep) begin
				step_q <= step_q + 1'b1;
			end
			vld_s1 <= (state_q == fvf_pkg::ST_HASH) && (step_q <= fvf_pkg::LastStep);
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= step_q;
		if (start) begin
			cur_q <= q_cmd;
			h_q   <= fvf_pkg::FnvBasis;
		end else if (vld_s1) begin
			if (hash_en) begin
				h_q <= h_next;
			end
			case (step_s1)
				fvf_pkg::StepAlg: begin
					alg_q <= d[2:0];
					fb_q  <= d[5:3];
				end
				fvf_pkg::StepAms: begin
					pan_q <= d[7:6];
					ams_q <= d[5:4];
					fms_q <= d[2:0];
				end
				fvf_pkg::StepFms:    timbre_q  <= h_next;
				fvf_pkg::StepFnumLo: fnum_lo_q <= d;
				fvf_pkg::StepBlock:  blk_q     <= d[5:0];
				default: ;
			endcase
		end
	end

	// result contents
	always_comb begin
		r_kind_d   = q_cmd.kind;
		r_chan_d   = {5'b00000, q_cmd.channel};
		r_reg_d    = '0;
		r_data_d   = q_cmd.key_slots;
		r_timbre_d = '0;
		r_voice_d  = '0;
		r_alg_d    = '0;
		r_fb_d     = '0;
		r_pan_d    = '0;
		r_ams_d    = '0;
		r_fms_d    = '0;
		r_bfn_d    = '0;
		if (state_q == fvf_pkg::ST_HASH) begin
			r_kind_d   = fvf_pkg::EV_NOTE_ON;
			r_chan_d   = {5'b00000, cur_q.channel};
			r_data_d   = cur_q.key_slots;
			r_timbre_d = timbre_q;
			r_voice_d  = h_next;
			r_alg_d    = alg_q;
			r_fb_d     = fb_q;
			r_pan_d    = pan_q;
			r_ams_d    = ams_q;
			r_fms_d    = fms_q;
			r_bfn_d    = {blk_q, fnum_lo_q};
		end else if (q_cmd.kind == fvf_pkg::EV_RAW) begin
			r_chan_d = fvf_pkg::RawChannel;
			r_reg_d  = q_cmd.reg_address;
			r_data_d = q_cmd.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			r_kind_q   <= r_kind_d;
			r_chan_q   <= r_chan_d;
			r_reg_q    <= r_reg_d;
			r_data_q   <= r_data_d;
			r_timbre_q <= r_timbre_d;
			r_voice_q  <= r_voice_d;
			r_alg_q    <= r_alg_d;
			r_fb_q     <= r_fb_d;
			r_pan_q    <= r_pan_d;
			r_ams_q    <= r_ams_d;
			r_fms_q    <= r_fms_d;
			r_bfn_q    <= r_bfn_d;
		end
	end

	assign result_out.valid         = res_valid_q;
	assign result_out.event_kind    = r_kind_q;
	assign result_out.event_channel = r_chan_q;
	assign result_out.event_reg     = r_reg_q;
	assign result_out.event_data    = r_data_q;
	assign result_out.timbre_digest = r_timbre_q;
	assign result_out.voice_digest  = r_voice_q;
	assign result_out.algorithm     = r_alg_q;
	assign result_out.feedback      = r_fb_q;
	assign result_out.pan           = r_pan_q;
	assign result_out.ams           = r_ams_q;
	assign result_out.fms           = r_fms_q;
	assign result_out.blk_fnum      = r_bfn_q;

endmodule

// ===== hw/rtl/fm_voice_fingerprint_unit.sv =====
// top level of the fm voice fingerprint unit
// a register write or note-off passes through the queue and the result register before its result is valid
// a note-on result is loaded when the sequencer finishes its 38 sequencer steps (36 hash bytes)
// throughput: one write or key-off per cycle while results are taken, none while a note-on is hashing
// reset: shadow cleared by a pass over all 512 entries with item_in.ready low, probe enabled
`timescale 1ns / 1ps
`include "fm_voice_fingerprint_unit_assert.svh"

module fm_voice_fingerprint_unit #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	fvf_in_if.sink                             item_in,
	fvf_out_if.source                          result_out,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [fvf_pkg::ApbAddrWidth-1:0]   paddr,
	input  logic [fvf_pkg::ApbDataWidth-1:0]   pwdata,
	output logic [fvf_pkg::ApbDataWidth-1:0]   prdata,
	output logic                               pready
);

	// configuration register
	logic probe_enabled_q;
	logic cfg_write;

	// front to queue
	logic          push;
	fvf_pkg::cmd_t push_cmd;
	logic          q_full;

	// queue to back
	logic          pop;
	fvf_pkg::cmd_t q_cmd;
	logic          q_nonempty;
	logic          clear_busy;

	// apb: zero wait states, register selected by the word address bit
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_enabled_q <= 1'b1;
		end else if (cfg_write && paddr[2] == fvf_pkg::CfgProbeEnabled) begin
			probe_enabled_q <= pwdata[0];
		end
	end

	// read back, unused addresses read as zero
	always_comb begin
		prdata = '0;
		if (paddr[2] == fvf_pkg::CfgProbeEnabled) begin
			prdata[0] = probe_enabled_q;
		end
	end

	// front end classifies each transaction and drops it when the probe is off
	fvf_front u_front (
		.item_in       (item_in),
		.probe_enabled (probe_enabled_q),
		.clear_busy    (clear_busy),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// decoupling queue: keeps writes flowing while the back end is hashing
	fvf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (q_cmd),
		.nonempty (q_nonempty)
	);

	// back end owns the shadow memory, so writes and note-on reads stay in order
	fvf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_cmd      (q_cmd),
		.pop        (pop),
		.clear_busy (clear_busy),
		.result_out (result_out)
	);

	// no transaction is taken while the shadow is being cleared
	`FVF_ASSERT_NEVER(a_no_accept_in_clear, clk, arst_n, item_in.valid && item_in.ready && clear_busy)
	// the queue never takes a command it has no room for
	`FVF_ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push && q_full && !pop)
	// commands only enter the queue with the probe enabled
	`FVF_ASSERT(a_push_needs_probe, clk, arst_n, push |-> probe_enabled_q)
	// the back end only pops a queue that holds something
	`FVF_ASSERT(a_pop_needs_entry, clk, arst_n, pop |-> q_nonempty)

endmodule

// ===== tb/sv/tb_fm_voice_fingerprint_unit.sv =====
// self-checking testbench of the fm voice fingerprint unit with its voice-hash scoreboard
`timescale 1ns / 1ps

package tb_fvf_pkg;

	localparam logic ModeWrite = 1'b0;
	localparam logic ModeKey   = 1'b1;

	localparam logic [63:0] FnvOffset = 64'hcbf29ce484222325;
	localparam logic [63:0] FnvMult   = 64'd1099511628211;

	typedef struct packed {
		logic       mode;
		logic [8:0] addr;
		logic [7:0] data;
		logic [2:0] channel;
		logic [7:0] mask;
	} fm_cmd_t;

	typedef struct packed {
		fvf_pkg::event_kind_t kind;
		logic [7:0]           channel;
		logic [8:0]           reg_addr;
		logic [7:0]           data;
		logic [63:0]          timbre;
		logic [63:0]          voice;
		logic [2:0]           alg;
		logic [2:0]           fb;
		logic [1:0]           pan;
		logic [1:0]           ams;
		logic [2:0]           fms;
		logic [13:0]          bfn;
	} voice_event_t;

	class voice_scoreboard;
		logic [7:0]   shadow [512];
		bit           enabled;
		voice_event_t pending [$];
		int           n_mismatch;
		int           n_raw;
		int           n_note_on;
		int           n_note_off;
		int           n_zero_voice;
		int           n_ignored;

		function new();
			foreach (shadow[i]) shadow[i] = 8'd0;
			enabled = 1'b1;
		endfunction

		function logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
			return (h ^ {56'd0, b}) * FnvMult;
		endfunction

		function logic [7:0] shadow_byte(logic bank, int r);
			return shadow[(bank ? 256 : 0) + (r & 255)];
		endfunction

		function void flag(string what, logic [63:0] exp, logic [63:0] got);
			if (exp === got)
				return;
			n_mismatch++;
			if (n_mismatch <= 10)
				$display("mismatch %0d: %s expected %0h got %0h", n_mismatch, what, exp, got);
		endfunction

		// work out the result of one accepted command
		function void note_input(fm_cmd_t c);
			voice_event_t e;
			logic [7:0]   v [32];
			logic [7:0]   r;
			logic [63:0]  h;
			logic         bank;
			int           n;
			int           o;
			if (!enabled) begin
				n_ignored++;
				return;
			end
			e = '0;
			if (c.mode == ModeWrite) begin
				shadow[c.addr] = c.data;
				e.kind = fvf_pkg::EV_RAW;
				e.channel = 8'hff;
				e.reg_addr = c.addr;
				e.data = c.data;
				n_raw++;
				pending.push_back(e);
				return;
			end
			e.channel = {5'd0, c.channel};
			e.data = c.mask;
			if (c.mask[7:4] == 4'd0) begin
				e.kind = fvf_pkg::EV_NOTE_OFF;
				n_note_off++;
				pending.push_back(e);
				return;
			end
			e.kind = fvf_pkg::EV_NOTE_ON;
			n_note_on++;
			foreach (v[i]) v[i] = 8'd0;
			if (c.channel <= 3'd5) begin
				bank = (c.channel >= 3'd3);
				n = c.channel % 3;
				for (int k = 0; k < 4; k++) begin
					o = 4 * k + n;
					r = shadow_byte(bank, fvf_pkg::RegMulDt + o);
					v[20 + k] = r & 8'h0f;
					v[24 + k] = (r >> 4) & 8'h07;
					v[k] = shadow_byte(bank, fvf_pkg::RegTl + o) & 8'h7f;
					v[4 + k] = shadow_byte(bank, fvf_pkg::RegAr + o) & 8'h1f;
					v[8 + k] = shadow_byte(bank, fvf_pkg::RegDr + o) & 8'h1f;
					v[12 + k] = shadow_byte(bank, fvf_pkg::RegSr + o) & 8'h1f;
					v[16 + k] = shadow_byte(bank, fvf_pkg::RegRr + o) & 8'h0f;
				end
				r = shadow_byte(bank, fvf_pkg::RegAlgFb + n);
				e.alg = r[2:0];
				e.fb = r[5:3];
				r = shadow_byte(bank, fvf_pkg::RegPanLfo + n);
				e.pan = r[7:6];
				e.ams = r[5:4];
				e.fms = r[2:0];
				r = shadow_byte(bank, fvf_pkg::RegBlock + n);
				e.bfn = {r[5:0], shadow_byte(bank, fvf_pkg::RegFnumLo + n)};
				v[28] = {5'd0, e.alg};
				v[29] = {5'd0, e.fb};
				v[30] = {6'd0, e.ams};
				v[31] = {5'd0, e.fms};
			end else begin
				n_zero_voice++;
			end
			h = FnvOffset;
			for (int k = 0; k < 32; k++) h = fnv_mix(h, v[k]);
			e.timbre = h;
			// tone class, four bytes little-endian
			h = fnv_mix(h, {4'd0, e.bfn[10:7]});
			h = fnv_mix(h, 8'd0);
			h = fnv_mix(h, 8'd0);
			h = fnv_mix(h, 8'd0);
			e.voice = h;
			pending.push_back(e);
		endfunction

		function void check_result(voice_event_t got);
			voice_event_t exp;
			if (pending.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("mismatch %0d: result with none expected, kind %0d channel %0d",
						n_mismatch, got.kind, got.channel);
				return;
			end
			exp = pending.pop_front();
			flag("event_kind", 64'(exp.kind), 64'(got.kind));
			flag("event_channel", 64'(exp.channel), 64'(got.channel));
			flag("event_reg", 64'(exp.reg_addr), 64'(got.reg_addr));
			flag("event_data", 64'(exp.data), 64'(got.data));
			flag("timbre_digest", exp.timbre, got.timbre);
			flag("voice_digest", exp.voice, got.voice);
			flag("algorithm", 64'(exp.alg), 64'(got.alg));
			flag("feedback", 64'(exp.fb), 64'(got.fb));
			flag("pan", 64'(exp.pan), 64'(got.pan));
			flag("ams", 64'(exp.ams), 64'(got.ams));
			flag("fms", 64'(exp.fms), 64'(got.fms));
			flag("blk_fnum", 64'(exp.bfn), 64'(got.bfn));
		endfunction
	endclass

endpackage

module tb_fm_voice_fingerprint_unit;
	import tb_fvf_pkg::*;

	// cycles with no transaction on either channel before the run is declared hung
	localparam int IdleLimit = 4000;
	// settle time after the last result, longer than a note-on hash takes
	localparam int DrainCycles = 60;
	// long receiver hold-off that backs the block up into its input
	localparam int LongHold = 400;
	localparam logic [fvf_pkg::ApbAddrWidth-1:0] ProbeEnAddr = {fvf_pkg::CfgProbeEnabled, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [fvf_pkg::ApbAddrWidth-1:0] paddr;
	logic [fvf_pkg::ApbDataWidth-1:0] pwdata;
	logic [fvf_pkg::ApbDataWidth-1:0] prdata;
	logic        pready;

	fvf_in_if  item_if ();
	fvf_out_if res_if ();

	voice_scoreboard sb;
	int n_driven;
	int in_accepts;
	int out_accepts;
	int idle_cycles;

	fm_voice_fingerprint_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (res_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// a register that shapes the voice of the given channel
	function automatic logic [8:0] voice_reg(logic [2:0] ch);
		logic       bank;
		logic [7:0] base;
		int         n;
		int         k;
		if (ch <= 3'd5) begin
			bank = (ch >= 3'd3);
			n = ch % 3;
		end else begin
			// invalid channel: any slot of any bank, including the unused fourth one
			bank = 1'($urandom_range(0, 1));
			n = $urandom_range(0, 3);
		end
		k = $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0: base = fvf_pkg::RegMulDt + 8'(4 * k);
			1: base = fvf_pkg::RegTl + 8'(4 * k);
			2: base = fvf_pkg::RegAr + 8'(4 * k);
			3: base = fvf_pkg::RegDr + 8'(4 * k);
			4: base = fvf_pkg::RegSr + 8'(4 * k);
			5: base = fvf_pkg::RegRr + 8'(4 * k);
			6: base = fvf_pkg::RegFnumLo;
			7: base = fvf_pkg::RegBlock;
			8: base = fvf_pkg::RegAlgFb;
			default: base = fvf_pkg::RegPanLfo;
		endcase
		return {bank, base + 8'(n)};
	endfunction

	// offer one command and hold it until the block takes it
	task automatic send_item(fm_cmd_t c);
		int gap;
		// every 200 commands, a stretch of 40 with no gaps at all
		gap = (n_driven % 200 < 40) ? 0 : pick_gap();
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.mode <= c.mode;
		item_if.reg_address <= c.addr;
		item_if.write_data <= c.data;
		item_if.channel <= c.channel;
		item_if.key_slots <= c.mask;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		n_driven++;
	endtask

	// unused fields of a command carry random junk
	task automatic send_write(logic [8:0] addr, logic [7:0] data);
		fm_cmd_t c;
		c = fm_cmd_t'(29'($urandom));
		c.mode = ModeWrite;
		c.addr = addr;
		c.data = data;
		send_item(c);
	endtask

	task automatic send_key(logic [2:0] ch, logic [7:0] mask);
		fm_cmd_t c;
		c = fm_cmd_t'(29'($urandom));
		c.mode = ModeKey;
		c.channel = ch;
		c.mask = mask;
		send_item(c);
	endtask

	// mostly: program part of a voice, key it on, maybe key it off; the rest is noise
	task automatic random_traffic(int n_items);
		int         start;
		int         nw;
		logic [2:0] ch;
		start = n_driven;
		while (n_driven - start < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				ch = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 5))
					: 3'($urandom_range(6, 7));
				nw = $urandom_range(1, 8);
				for (int k = 0; k < nw; k++) send_write(voice_reg(ch), 8'($urandom));
				send_key(ch, {4'($urandom_range(1, 15)), 4'($urandom)});
				if ($urandom_range(0, 1) == 1)
					send_key(ch, {4'd0, 4'($urandom)});
			end else begin
				send_item(fm_cmd_t'(29'($urandom)));
			end
		end
	endtask

	// stop offering and wait until every predicted result is back
	task automatic drain();
		item_if.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic cfg_write(logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ProbeEnAddr;
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.enabled = value;
		@(posedge clk);
	endtask

	task automatic cfg_read_check(logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ProbeEnAddr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.flag("probe_enabled readback", {63'd0, value}, {32'd0, prdata});
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: random ready with bursts and stalls, plus two long hold-offs
	initial begin : receiver
		int run;
		int stall;
		int holds_done;
		int hold_at;
		holds_done = 0;
		hold_at = 300;
		@(posedge clk);
		forever begin
			if (holds_done < 2 && in_accepts >= hold_at) begin
				// sender keeps offering, so the queue fills and input ready drops
				res_if.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				holds_done++;
				hold_at = 1200;
			end else begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 30);
				res_if.ready <= 1'b1;
				repeat (run) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					res_if.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// monitor both channels and watch for a hang
	always @(posedge clk) begin
		voice_event_t got;
		bit           moved;
		if (arst_n) begin
			moved = 1'b0;
			if (item_if.valid && item_if.ready) begin
				sb.note_input({item_if.mode, item_if.reg_address, item_if.write_data,
					item_if.channel, item_if.key_slots});
				in_accepts++;
				moved = 1'b1;
			end
			if (res_if.valid && res_if.ready) begin
				got.kind = fvf_pkg::event_kind_t'(res_if.event_kind);
				got.channel = res_if.event_channel;
				got.reg_addr = res_if.event_reg;
				got.data = res_if.event_data;
				got.timbre = res_if.timbre_digest;
				got.voice = res_if.voice_digest;
				got.alg = res_if.algorithm;
				got.fb = res_if.feedback;
				got.pan = res_if.pan;
				got.ams = res_if.ams;
				got.fms = res_if.fms;
				got.bfn = res_if.blk_fnum;
				sb.check_result(got);
				out_accepts++;
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: no transaction for %0d cycles, %0d results outstanding",
					IdleLimit, sb.pending.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		n_driven = 0;
		in_accepts = 0;
		out_accepts = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_if.valid <= 1'b0;
		item_if.mode <= ModeWrite;
		item_if.reg_address <= '0;
		item_if.write_data <= '0;
		item_if.channel <= '0;
		item_if.key_slots <= '0;
		res_if.ready <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the shadow clear pass after reset shows up as input ready held low
		cfg_write(1'b1);
		cfg_read_check(1'b1);

		// directed: field extremes, zero shadow, full-scale voice, both banks
		send_write(9'h000, 8'h00);
		send_write(9'h1ff, 8'hff);
		send_key(3'd0, 8'hf0);
		send_key(3'd0, 8'h0f);
		send_key(3'd7, 8'h00);
		send_write({1'b0, fvf_pkg::RegMulDt}, 8'hff);
		send_write({1'b0, fvf_pkg::RegTl}, 8'hff);
		send_write({1'b0, fvf_pkg::RegRr + 8'd12}, 8'hff);
		send_write({1'b0, fvf_pkg::RegAlgFb}, 8'hff);
		send_write({1'b0, fvf_pkg::RegPanLfo}, 8'hff);
		send_write({1'b0, fvf_pkg::RegBlock}, 8'hff);
		send_write({1'b0, fvf_pkg::RegFnumLo}, 8'hff);
		send_key(3'd0, 8'hff);
		send_write({1'b1, fvf_pkg::RegPanLfo + 8'd2}, 8'hc5);
		send_write({1'b1, fvf_pkg::RegBlock + 8'd2}, 8'h3f);
		send_write({1'b1, fvf_pkg::RegFnumLo + 8'd2}, 8'h80);
		send_write({1'b1, fvf_pkg::RegAr + 8'd14}, 8'h1f);
		send_key(3'd5, 8'h10);
		// channels 6 and 7 hash an all-zero voice
		send_key(3'd6, 8'hf0);
		send_key(3'd7, 8'hff);
		send_key(3'd3, 8'h80);
		send_key(3'd5, 8'hef);
		send_write(9'h0ff, 8'h00);

		random_traffic(720);
		drain();

		// probe off: everything is taken and dropped, no results
		cfg_write(1'b0);
		cfg_read_check(1'b0);
		random_traffic(120);
		drain();

		cfg_write(1'b1);
		cfg_read_check(1'b1);
		random_traffic(760);
		drain();

		$display("covered %0d raw writes, %0d note-ons (%0d on invalid channels), %0d note-offs",
			sb.n_raw, sb.n_note_on, sb.n_zero_voice, sb.n_note_off);
		$display("%0d commands dropped with the probe off, %0d results checked, %0d mismatches",
			sb.n_ignored, out_accepts, sb.n_mismatch);
		if (sb.pending.size() != 0)
			$display("%0d expected results never arrived", sb.pending.size());
		if (sb.n_mismatch == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
